// File: hw/rtl/ssetab_pkg.sv
// shared types, constants and field layout for the sparse set table
// no dependencies; imported by every module of the block
`default_nettype none

package ssetab_pkg;

    // table geometry
    localparam int unsigned KEY_SPACE  = 1024;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned KEY_W      = $clog2(KEY_SPACE);
    localparam int unsigned SLOT_W     = KEY_W;
    localparam int unsigned CNT_W      = $clog2(KEY_SPACE + 1);

    // stream field widths
    localparam int unsigned REQ_W       = 3;
    localparam int unsigned KEY_FIELD_W = 10;
    localparam int unsigned PAYLOAD_W   = 32;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned COUNT_W     = 11;

    // input tdata layout
    localparam int unsigned IN_KEY_LSB     = 0;
    localparam int unsigned IN_SLOT_LSB    = IN_KEY_LSB + KEY_FIELD_W;
    localparam int unsigned IN_PAYLOAD_LSB = IN_SLOT_LSB + KEY_FIELD_W;
    localparam int unsigned IN_TDATA_W     = 56;

    // output tdata layout
    localparam int unsigned OUT_PAYLOAD_LSB = 0;
    localparam int unsigned OUT_KEY_LSB     = OUT_PAYLOAD_LSB + PAYLOAD_W;
    localparam int unsigned OUT_SLOT_LSB    = OUT_KEY_LSB + KEY_FIELD_W;
    localparam int unsigned OUT_COUNT_LSB   = OUT_SLOT_LSB + KEY_FIELD_W;
    localparam int unsigned OUT_USED_W      = OUT_COUNT_LSB + COUNT_W;
    localparam int unsigned OUT_TDATA_W     = 64;
    localparam int unsigned OUT_PAD_W       = OUT_TDATA_W - OUT_USED_W;
    localparam int unsigned OUT_TUSER_W     = STATUS_W + 1;
    localparam int unsigned OUT_FOUND_BIT   = STATUS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT      = 3'd0,
        REQ_REMOVE      = 3'd1,
        REQ_LOOKUP_KEY  = 3'd2,
        REQ_LOOKUP_SLOT = 3'd3,
        REQ_CLEAR       = 3'd4
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_ABSENT    = 3'd1,
        STAT_PRESENT   = 3'd2,
        STAT_BAD_SLOT  = 3'd3,
        STAT_KEY_RANGE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_DENSE,
        S_EXEC
    } state_t;

    // one dense entry: member key and its payload
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [DATA_WIDTH-1:0] payload;
    } dense_entry_t;

    typedef struct packed {
        logic              re;
        logic [KEY_W-1:0]  raddr;
        logic              we;
        logic [KEY_W-1:0]  waddr;
        logic [SLOT_W-1:0] wdata;
    } sparse_req_t;

    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr_a;
        logic [SLOT_W-1:0] raddr_b;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        dense_entry_t      wdata;
    } dense_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/ssetab_sparse_ram.sv
// sparse map memory: key to dense slot, one read and one write port
// depends on ssetab_pkg
`default_nettype none

module ssetab_sparse_ram
    import ssetab_pkg::*;
(
    input  wire logic              clk,
    input  wire sparse_req_t       req,
    output logic      [SLOT_W-1:0] rdata
);

    logic [SLOT_W-1:0] mem [KEY_SPACE];
    logic [SLOT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ssetab_dense_ram.sv
// dense memory: slot to key and payload, two read ports and one write port
// depends on ssetab_pkg
`default_nettype none

module ssetab_dense_ram
    import ssetab_pkg::*;
(
    input  wire logic  clk,
    input  wire dense_req_t req,
    output dense_entry_t rdata_a,
    output dense_entry_t rdata_b
);

    dense_entry_t mem [KEY_SPACE];
    dense_entry_t rdata_a_reg;
    dense_entry_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_a_reg <= mem[req.raddr_a];
            rdata_b_reg <= mem[req.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ssetab_ctrl.sv
// request sequencer: reads both memories, decides the request, writes back
// and holds the result register; depends on ssetab_pkg
`default_nettype none

module ssetab_ctrl
    import ssetab_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [REQ_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic      [OUT_TUSER_W-1:0] m_axis_tuser,
    output sparse_req_t                 sparse_req,
    input  wire logic [SLOT_W-1:0]      sparse_rdata,
    output dense_req_t                  dense_req,
    input  wire dense_entry_t           dense_rdata_a,
    input  wire dense_entry_t           dense_rdata_b
);

    state_t state_reg, state_next;

    logic [REQ_W-1:0]       req_reg;
    logic [KEY_FIELD_W-1:0] key_reg;
    logic [KEY_FIELD_W-1:0] slot_reg;
    logic [DATA_WIDTH-1:0]  pin_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [OUT_TUSER_W-1:0] out_tuser_reg, out_tuser_next;
    logic [KEY_W-1:0]       init_addr_reg, init_addr_next;

    logic             accept;
    logic             out_free;
    logic             exec_fire;
    logic             dense_re;
    logic             in_ready;
    logic             init_run;
    logic [CNT_W-1:0] count_m1;
    logic             key_oor;
    logic             member;

    status_t                status;
    logic                   found;
    logic [PAYLOAD_W-1:0]   pout;
    logic [KEY_FIELD_W-1:0] kout;
    logic [KEY_FIELD_W-1:0] sout;

    assign accept   = s_axis_tvalid && in_ready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign count_m1 = count_reg - CNT_W'(1);
    assign key_oor  = 32'(key_reg) >= KEY_SPACE;

    // clearing pass after reset walks every entry once
    assign init_addr_next = init_run ? init_addr_reg + KEY_W'(1) : init_addr_reg;

    // stale map entries never matter: a key is a member only when its slot
    // is below the count and the dense entry there points back to it
    assign member = !key_oor && (CNT_W'(sparse_rdata) < count_reg)
                    && (dense_rdata_a.key == key_reg[KEY_W-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_addr_reg == KEY_W'(KEY_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DENSE;
                end
            end
            S_DENSE:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        dense_re  = 1'b0;
        exec_fire = 1'b0;
        init_run  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                init_run = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_DENSE:
            begin
                dense_re = 1'b1;
            end
            S_EXEC:
            begin
                exec_fire = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // request decode and write-back
    always_comb
    begin
        status     = STAT_OK;
        found      = 1'b0;
        pout       = '0;
        kout       = '0;
        sout       = '0;
        count_next = count_reg;

        sparse_req.re    = accept;
        sparse_req.raddr = s_axis_tdata[IN_KEY_LSB +: KEY_W];
        sparse_req.we    = 1'b0;
        sparse_req.waddr = key_reg[KEY_W-1:0];
        sparse_req.wdata = count_reg[SLOT_W-1:0];

        dense_req.re            = dense_re;
        dense_req.raddr_a       = (req_reg == REQ_LOOKUP_SLOT) ? slot_reg[SLOT_W-1:0]
                                                                : sparse_rdata;
        dense_req.raddr_b       = count_m1[SLOT_W-1:0];
        dense_req.we            = 1'b0;
        dense_req.waddr         = count_reg[SLOT_W-1:0];
        dense_req.wdata.key     = key_reg[KEY_W-1:0];
        dense_req.wdata.payload = pin_reg;

        if (key_oor && (req_reg == REQ_INSERT || req_reg == REQ_REMOVE
                        || req_reg == REQ_LOOKUP_KEY))
        begin
            status = STAT_KEY_RANGE;
        end
        else
        begin
            unique case (req_reg)
                REQ_INSERT:
                begin
                    if (member)
                    begin
                        status = STAT_PRESENT;
                        found  = 1'b1;
                        sout   = KEY_FIELD_W'(sparse_rdata);
                        pout   = PAYLOAD_W'(dense_rdata_a.payload);
                    end
                    else if (count_reg < CNT_W'(KEY_SPACE))
                    begin
                        sparse_req.we = exec_fire;
                        dense_req.we  = exec_fire;
                        sout          = KEY_FIELD_W'(count_reg[SLOT_W-1:0]);
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                REQ_REMOVE:
                begin
                    if (!member)
                    begin
                        status = STAT_ABSENT;
                    end
                    else
                    begin
                        // last member moves into the vacated slot
                        found            = 1'b1;
                        sout             = KEY_FIELD_W'(sparse_rdata);
                        pout             = PAYLOAD_W'(dense_rdata_a.payload);
                        dense_req.we     = exec_fire;
                        dense_req.waddr  = sparse_rdata;
                        dense_req.wdata  = dense_rdata_b;
                        sparse_req.we    = exec_fire;
                        sparse_req.waddr = dense_rdata_b.key;
                        sparse_req.wdata = sparse_rdata;
                        count_next       = count_m1;
                    end
                end
                REQ_LOOKUP_KEY:
                begin
                    if (!member)
                    begin
                        status = STAT_ABSENT;
                    end
                    else
                    begin
                        found = 1'b1;
                        sout  = KEY_FIELD_W'(sparse_rdata);
                        pout  = PAYLOAD_W'(dense_rdata_a.payload);
                    end
                end
                REQ_LOOKUP_SLOT:
                begin
                    if (CNT_W'(slot_reg) >= count_reg)
                    begin
                        status = STAT_BAD_SLOT;
                    end
                    else
                    begin
                        found = 1'b1;
                        kout  = KEY_FIELD_W'(dense_rdata_a.key);
                        pout  = PAYLOAD_W'(dense_rdata_a.payload);
                        sout  = slot_reg;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status = STAT_OK;
                end
            endcase
        end

        if (!exec_fire)
        begin
            count_next = count_reg;
        end

        if (init_run)
        begin
            sparse_req.we   = 1'b1;
            sparse_req.waddr = init_addr_reg;
            sparse_req.wdata = '0;
            dense_req.we    = 1'b1;
            dense_req.waddr = init_addr_reg;
            dense_req.wdata = '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
            out_tdata_next = {{OUT_PAD_W{1'b0}}, COUNT_W'(count_next), sout, kout, pout};
            out_tuser_next = {found, status};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            init_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            init_addr_reg <= init_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_axis_tuser;
            key_reg  <= s_axis_tdata[IN_KEY_LSB +: KEY_FIELD_W];
            slot_reg <= s_axis_tdata[IN_SLOT_LSB +: KEY_FIELD_W];
            pin_reg  <= s_axis_tdata[IN_PAYLOAD_LSB +: DATA_WIDTH];
        end
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sparse_set_table_unit.sv
// sparse set table: a request stream in and one result per request out.
//
// slave channel: tuser carries the request type (insert, remove by key,
// lookup by key, lookup by slot, clear); tdata carries key, slot and payload.
// master channel: tuser carries status and a found flag; tdata carries the
// payload found, the key at a slot, the slot of the key and the member count
// after the request.
// a request moves through idle, dense and exec: the transfer edge reads the key map,
// the dense state reads the dense store at the mapped slot and at the last
// member, and exec decides and writes both memories back. no new request
// is taken until the current one has left exec.
// results sit in an output register: a request can be taken while the last
// result waits, but a second result stalls in the decide cycle until the
// receiver takes the first.
// reset zeroes the member count and starts a pass that clears both memories,
// one entry a cycle; tready stays low until that pass has cleared every entry,
// and only then is the first request taken.
// depends on ssetab_pkg, ssetab_ctrl, ssetab_sparse_ram, ssetab_dense_ram
`default_nettype none

module sparse_set_table_unit
    import ssetab_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // key, slot, payload_in
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // payload_out, key_out, slot_out, member_count
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // status, found
    output logic      [OUT_TUSER_W-1:0] m_axis_tuser
);

    sparse_req_t       sparse_req;
    logic [SLOT_W-1:0] sparse_rdata;
    dense_req_t        dense_req;
    dense_entry_t      dense_rdata_a;
    dense_entry_t      dense_rdata_b;

    ssetab_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .sparse_req    (sparse_req),
        .sparse_rdata  (sparse_rdata),
        .dense_req     (dense_req),
        .dense_rdata_a (dense_rdata_a),
        .dense_rdata_b (dense_rdata_b)
    );

    ssetab_sparse_ram u_sparse_ram (
        .clk   (clk),
        .req   (sparse_req),
        .rdata (sparse_rdata)
    );

    ssetab_dense_ram u_dense_ram (
        .clk     (clk),
        .req     (dense_req),
        .rdata_a (dense_rdata_a),
        .rdata_b (dense_rdata_b)
    );

`ifndef SYNTH
    // no second request is taken while one is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // the dense read comes in the cycle after the key map read
    assert property (@(posedge clk) disable iff (!rst_n)
        sparse_req.re |=> dense_req.re)
        else $error("dense read did not follow key map read");

    // the member count never exceeds the key space
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[OUT_COUNT_LSB +: COUNT_W] <= COUNT_W'(KEY_SPACE)))
        else $error("member count beyond key space");

    // a found member only comes with a clean or duplicate status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[OUT_FOUND_BIT]) |->
            (m_axis_tuser[STATUS_W-1:0] == STAT_OK
             || m_axis_tuser[STATUS_W-1:0] == STAT_PRESENT))
        else $error("found flag with an error status");
`endif

endmodule

`default_nettype wire
